@@ sv/qrt_pkg.sv @@
package qrt_pkg;

  localparam int ID_W       = 31;
  localparam int OP_W       = 2;
  localparam int CTR_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int DEF_SLOTS  = 16;

  localparam logic [STATUS_W-1:0] ST_PENDING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SUCCESS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAILURE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam logic MODE_OPEN  = 1'b0;
  localparam logic MODE_REPLY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLICA = 1'b1;

  localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
  localparam logic [CTR_W-1:0] QUORUM_RESET  = 2'd2;
  localparam logic [CTR_W-1:0] REPLICA_RESET = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic cmp;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/qrt_if.sv @@
interface qrt_in_if import qrt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [ID_W-1:0] trans_id;
  logic [OP_W-1:0] op_kind;
  logic            reply_ok;

  modport source (output valid, mode, trans_id, op_kind, reply_ok, input ready);
  modport sink   (input valid, mode, trans_id, op_kind, reply_ok, output ready);
endinterface

interface qrt_out_if import qrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     done_id;
  logic [OP_W-1:0]     done_op;

  modport source (output valid, status, done_id, done_op, input ready);
  modport sink   (input valid, status, done_id, done_op, output ready);
endinterface

@@ sv/qrt_ctrl.sv @@
module qrt_ctrl import qrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dp_st,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (dp_st.hit || dp_st.last) state_nxt = S_DECIDE;
        else state_nxt = S_READ;
      end
      S_DECIDE: begin
        if (dp_st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: begin
        cmd.rd = 1'b1;
      end
      S_CMP: begin
        cmd.cmp  = 1'b1;
        cmd.step = !dp_st.hit && !dp_st.last;
      end
      S_DECIDE: begin
        cmd.commit = dp_st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/qrt_datapath.sv @@
module qrt_datapath import qrt_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_mode,
  input  logic [ID_W-1:0]       in_trans_id,
  input  logic [OP_W-1:0]       in_op_kind,
  input  logic                  in_reply_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_done_id,
  output logic [OP_W-1:0]       out_done_op,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            dp_st
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [OP_W-1:0]  op;
    logic [CTR_W-1:0] replies;
    logic [CTR_W-1:0] successes;
  } slot_entry_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
    return (c == CTR_MAX) ? c : c + CTR_W'(1);
  endfunction

  slot_entry_t slot_mem [SLOTS];
  slot_entry_t rd_data_r;
  logic [SLOTS-1:0] slot_valid_r;

  logic [CTR_W-1:0] quorum_r;
  logic [CTR_W-1:0] replica_r;

  logic            item_mode_r;
  logic [ID_W-1:0] item_id_r;
  logic [OP_W-1:0] item_op_r;
  logic            item_ok_r;

  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] found_idx_r;
  logic              free_seen_r;
  logic [SLOT_W-1:0] free_idx_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [OP_W-1:0]     out_op_r;

  logic                hit;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_idx;
  slot_entry_t         wr_data;
  logic                set_valid;
  logic                clr_valid;
  logic [STATUS_W-1:0] res_status;
  logic [OP_W-1:0]     res_op;
  logic [CTR_W-1:0]    new_rep;
  logic [CTR_W-1:0]    new_suc;

  assign hit = slot_valid_r[idx_r] && (rd_data_r.id == item_id_r);

  assign dp_st.hit      = hit;
  assign dp_st.last     = (idx_r == LAST_IDX);
  assign dp_st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quorum_r  <= QUORUM_RESET;
      replica_r <= REPLICA_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_QUORUM:  quorum_r  <= cfg_data;
        CFG_REPLICA: replica_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode_r <= in_mode;
      item_id_r   <= in_trans_id;
      item_op_r   <= in_op_kind;
      item_ok_r   <= in_reply_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      found_r     <= 1'b0;
      free_seen_r <= 1'b0;
    end else if (cmd.load) begin
      idx_r       <= '0;
      found_r     <= 1'b0;
      free_seen_r <= 1'b0;
    end else begin
      if (cmd.step) idx_r <= idx_r + SLOT_W'(1);
      if (cmd.cmp && hit) found_r <= 1'b1;
      if (cmd.cmp && !slot_valid_r[idx_r] && !free_seen_r) free_seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp && hit) found_idx_r <= idx_r;
    if (cmd.cmp && !slot_valid_r[idx_r] && !free_seen_r) free_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data_r <= slot_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_idx] <= wr_data;
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = found_idx_r;
    wr_data    = rd_data_r;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    res_status = ST_PENDING;
    res_op     = item_op_r;
    new_rep    = sat_inc(rd_data_r.replies);
    new_suc    = item_ok_r ? sat_inc(rd_data_r.successes) : rd_data_r.successes;
    if (item_mode_r == MODE_OPEN) begin
      if (found_r) begin
        res_op = rd_data_r.op;
      end else if (free_seen_r) begin
        wr_en             = cmd.commit;
        wr_idx            = free_idx_r;
        wr_data.id        = item_id_r;
        wr_data.op        = item_op_r;
        wr_data.replies   = '0;
        wr_data.successes = '0;
        set_valid         = cmd.commit;
      end else begin
        res_status = ST_FULL;
      end
    end else if (!found_r) begin
      res_status = ST_DROPPED;
      res_op     = '0;
    end else begin
      res_op = rd_data_r.op;
      if (new_suc >= quorum_r) begin
        res_status = ST_SUCCESS;
        clr_valid  = cmd.commit;
      end else if (new_rep >= replica_r) begin
        res_status = ST_FAILURE;
        clr_valid  = cmd.commit;
      end else begin
        wr_en             = cmd.commit;
        wr_data.replies   = new_rep;
        wr_data.successes = new_suc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (set_valid) begin
      slot_valid_r[free_idx_r] <= 1'b1;
    end else if (clr_valid) begin
      slot_valid_r[found_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_id_r     <= item_id_r;
      out_op_r     <= res_op;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_done_id = out_id_r;
  assign out_done_op = out_op_r;

endmodule

@@ sv/quorum_reply_tracker.sv @@
// Quorum reply tracker: table of outstanding replicated transactions.
// in_ch carries open items (mode 0) and replica replies (mode 1); out_ch
// returns exactly one result per item: status, transaction id and op kind.
// Both channels transfer on a clock edge with valid and ready high.
// cfg_we/cfg_idx/cfg_data write quorum_needed (index 0) and replica_count
// (index 1); write them only while the block is idle.
// Each item scans the slots from index 0 until the matching slot or the
// last slot, then its result is registered in the decide step. The slot
// table sits in a single-port memory with a registered read, and each
// slot takes a read state and then a compare state. One item is in
// flight at a time: a new item is taken only once the previous one has
// left the decide step.
// Reset clears all slot valid marks and restores quorum 2 / replicas 3.
// If out_ch stalls, the next item may still be taken and scanned; it waits
// in the decide step until the held result has been transferred.
module quorum_reply_tracker import qrt_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  qrt_in_if.sink                in_ch,
  qrt_out_if.source             out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  qrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .dp_st    (dp_st),
    .cmd      (cmd)
  );

  qrt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_mode     (in_ch.mode),
    .in_trans_id (in_ch.trans_id),
    .in_op_kind  (in_ch.op_kind),
    .in_reply_ok (in_ch.reply_ok),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_done_id (out_ch.done_id),
    .out_done_op (out_ch.done_op),
    .cmd         (cmd),
    .dp_st       (dp_st)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import qrt_pkg::*;

  localparam int SLOTS          = DEF_SLOTS;
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int IDLE_PCT       = 38;
  localparam int STRAY_PCT      = 10;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd3;
  localparam logic [ID_W-1:0] ID_MAX    = '1;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] id;
    logic [OP_W-1:0] op;
    logic            ok;
  } txn_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [OP_W-1:0]     op;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  qrt_in_if  in_ch ();
  qrt_out_if out_ch ();

  quorum_reply_tracker #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor state
  logic            tbl_valid [SLOTS];
  logic [ID_W-1:0] tbl_id    [SLOTS];
  logic [OP_W-1:0] tbl_op    [SLOTS];
  logic [CTR_W-1:0] tbl_replies [SLOTS];
  logic [CTR_W-1:0] tbl_succ    [SLOTS];
  logic [CTR_W-1:0] quorum_cfg  = QUORUM_RESET;
  logic [CTR_W-1:0] replica_cfg = REPLICA_RESET;
  logic [ID_W-1:0]  closed_id   = '0;

  verdict_t verdict_q [$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  logic     no_idle = 1'b0;
  logic     hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic verdict_t resolve_txn(input txn_t t);
    verdict_t v;
    int hit;
    int free_slot;
    hit = SLOTS;
    free_slot = SLOTS;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (tbl_valid[s] && tbl_id[s] == t.id) hit = s;
      if (!tbl_valid[s]) free_slot = s;
    end
    v.id = t.id;
    v.op = t.op;
    v.status = ST_PENDING;
    if (t.mode == MODE_OPEN) begin
      if (hit < SLOTS) begin
        v.op = tbl_op[hit];
      end else if (free_slot < SLOTS) begin
        tbl_valid[free_slot] = 1'b1;
        tbl_id[free_slot] = t.id;
        tbl_op[free_slot] = t.op;
        tbl_replies[free_slot] = '0;
        tbl_succ[free_slot] = '0;
      end else begin
        v.status = ST_FULL;
      end
    end else if (hit == SLOTS) begin
      v.status = ST_DROPPED;
      v.op = '0;
    end else begin
      v.op = tbl_op[hit];
      if (tbl_replies[hit] != CTR_MAX) tbl_replies[hit]++;
      if (t.ok && tbl_succ[hit] != CTR_MAX) tbl_succ[hit]++;
      if (tbl_succ[hit] >= quorum_cfg) begin
        v.status = ST_SUCCESS;
        tbl_valid[hit] = 1'b0;
        closed_id = t.id;
      end else if (tbl_replies[hit] >= replica_cfg) begin
        v.status = ST_FAILURE;
        tbl_valid[hit] = 1'b0;
        closed_id = t.id;
      end
    end
    return v;
  endfunction

  task automatic send_txn(input logic mode, input logic [ID_W-1:0] id,
                          input logic [OP_W-1:0] op, input logic ok);
    txn_t t;
    verdict_t v;
    t = '{mode: mode, id: id, op: op, ok: ok};
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= t.mode;
    in_ch.trans_id <= t.id;
    in_ch.op_kind  <= t.op;
    in_ch.reply_ok <= t.ok;
    do @(posedge clk); while (!in_ch.ready);
    v = resolve_txn(t);
    verdict_q = {verdict_q, v};
  endtask

  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers in back-to-back cycles; only called with the block idle
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] quorum,
                               input logic [CFG_DATA_W-1:0] replicas);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_QUORUM;
    cfg_data <= quorum;
    @(posedge clk);
    cfg_idx  <= CFG_REPLICA;
    cfg_data <= replicas;
    @(posedge clk);
    cfg_we   <= 1'b0;
    quorum_cfg  = quorum;
    replica_cfg = replicas;
  endtask

  task automatic send_random_txn(input int open_pct);
    int pick;
    int live [$];
    logic [ID_W-1:0] id;
    pick = $urandom_range(99);
    id = ID_W'($urandom());
    for (int s = 0; s < SLOTS; s++)
      if (tbl_valid[s]) live = {live, s};
    if (pick < open_pct || live.size() == 0) begin
      // mostly fresh ids, now and then one already held
      if (live.size() != 0 && $urandom_range(9) == 0)
        id = tbl_id[live[$urandom_range(live.size() - 1)]];
      send_txn(MODE_OPEN, id, OP_W'($urandom_range(3)), 1'($urandom_range(1)));
    end else if (pick < open_pct + STRAY_PCT) begin
      if ($urandom_range(1)) id = closed_id;
      send_txn(MODE_REPLY, id, OP_W'($urandom_range(3)), 1'($urandom_range(1)));
    end else begin
      id = tbl_id[live[$urandom_range(live.size() - 1)]];
      send_txn(MODE_REPLY, id, OP_W'($urandom_range(3)), $urandom_range(99) < 60);
    end
  endtask

  task automatic test_basic_flow();
    send_txn(MODE_OPEN,  '0,     OP_CREATE, 1'b1);
    send_txn(MODE_OPEN,  ID_MAX, OP_DELETE, 1'b0);
    send_txn(MODE_OPEN,  '0,     OP_UPDATE, 1'b0);
    send_txn(MODE_REPLY, 31'd5,  OP_READ,   1'b1);
    send_txn(MODE_REPLY, '0,     OP_DELETE, 1'b1);
    send_txn(MODE_REPLY, ID_MAX, OP_CREATE, 1'b0);
    send_txn(MODE_REPLY, '0,     OP_CREATE, 1'b1);
    send_txn(MODE_REPLY, '0,     OP_CREATE, 1'b1);
    send_txn(MODE_REPLY, ID_MAX, OP_READ,   1'b1);
    send_txn(MODE_REPLY, ID_MAX, OP_UPDATE, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_table_full();
    logic [ID_W-1:0] ids [SLOTS + 1];
    apply_setting(2'd1, 2'd1);
    for (int i = 0; i <= SLOTS; i++) begin
      ids[i] = 31'h2AAA_AA00 ^ ID_W'(i);
      send_txn(MODE_OPEN, ids[i], OP_READ ^ i[1:0], 1'b0);
    end
    send_txn(MODE_OPEN, ids[3], OP_CREATE, 1'b1);
    for (int i = 0; i < SLOTS; i++)
      send_txn(MODE_REPLY, ids[i], OP_CREATE, i[0]);
    drain_verdicts();
  endtask

  task automatic test_backpressure();
    apply_setting(QUORUM_RESET, REPLICA_RESET);
    hold_off_req <= 1'b1;
    @(posedge clk);
    hold_off_req <= 1'b0;
    for (int i = 0; i < 40; i++) send_random_txn(45);
    drain_verdicts();
    for (int i = 0; i < 20; i++) send_random_txn(40);
    drain_verdicts();
  endtask

  task automatic test_random_mix();
    logic [CFG_DATA_W-1:0] q_set [10] =
      '{2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0};
    logic [CFG_DATA_W-1:0] r_set [10] =
      '{2'd3, 2'd1, 2'd3, 2'd2, 2'd0, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
    int open_set [10] = '{40, 35, 45, 30, 30, 30, 50, 60, 40, 35};
    for (int p = 0; p < 10; p++) begin
      apply_setting(q_set[p], r_set[p]);
      no_idle <= (p == 6);
      for (int i = 0; i < 190; i++) send_random_txn(open_set[p]);
      drain_verdicts();
    end
    no_idle <= 1'b0;
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_off_req) begin
      stall_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("result with none outstanding: status %0d id %h",
               out_ch.status, out_ch.done_id);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.done_id !== want.id) begin
          $error("done_id: expected %h, got %h", want.id, out_ch.done_id);
          mismatches++;
        end
        if (out_ch.done_op !== want.op) begin
          $error("done_op: expected %0d, got %0d", want.op, out_ch.done_op);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_QUORUM;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_OPEN;
    in_ch.trans_id <= '0;
    in_ch.op_kind  <= OP_CREATE;
    in_ch.reply_ok <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_flow();
    test_table_full();
    test_backpressure();
    test_random_mix();

    drain_verdicts();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ quorum_reply_tracker.f @@
sv/qrt_pkg.sv
sv/qrt_if.sv
sv/qrt_ctrl.sv
sv/qrt_datapath.sv
sv/quorum_reply_tracker.sv
tb/tb.sv
